### hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define TTS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### hw/rtl/tts_pkg.sv
// Types and constants of the tick task scheduler.
package tts_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        CMD_TICK         = 2'd0,
        CMD_ADD_PERIODIC = 2'd1,
        CMD_ADD_ONESHOT  = 2'd2,
        CMD_DISPATCH     = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2,
        ST_SAT  = 2'd3
    } status_e;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
    } dp_sts_t;

endpackage

### hw/rtl/tts_req_if.sv
// Request channel of the tick task scheduler.
interface tts_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  task_tag;
    logic [15:0] interval_ticks;

    modport source (output valid, output command, output task_tag, output interval_ticks,
                    input ready);
    modport sink (input valid, input command, input task_tag, input interval_ticks,
                  output ready);
endinterface

### hw/rtl/tts_rsp_if.sv
// Result channel of the tick task scheduler.
interface tts_rsp_if;
    logic       valid;
    logic       ready;
    logic       dispatch_valid;
    logic [7:0] dispatched_tag;
    logic [3:0] dispatched_slot;
    logic [1:0] status;

    modport source (output valid, output dispatch_valid, output dispatched_tag,
                    output dispatched_slot, output status, input ready);
    modport sink (input valid, input dispatch_valid, input dispatched_tag,
                  input dispatched_slot, input status, output ready);
endinterface

### hw/rtl/tts_ctrl.sv
// Controller state machine of the tick task scheduler.
`include "assert_macros.svh"

module tts_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output tts_pkg::dp_cmd_t cmd,
    input  tts_pkg::dp_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.start     = 1'b1;
                    in_ready_next = 1'b0;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.step = 1'b1;
                if (sts.done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    in_ready_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                in_ready_next  = 1'b1;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    `TTS_NEVER(a_ready_and_valid, clk, rst_n, in_ready_reg && out_valid_reg, "request taken while result held")
    `TTS_ASSERT(a_done_gives_result, clk, rst_n, (state_reg == S_EXEC) && sts.done |=> out_valid_reg, "finished walk gave no result")
    `TTS_ASSERT(a_taken_reopens, clk, rst_n, out_valid_reg && out_ready |=> in_ready_reg, "result taken but input stays closed")

endmodule

### hw/rtl/tts_datapath.sv
// Slot table, slot walk and result registers of the tick task scheduler.
`include "assert_macros.svh"

module tts_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tts_pkg::dp_cmd_t        cmd,
    output tts_pkg::dp_sts_t        sts,
    input  logic [1:0]              command,
    input  logic [7:0]              task_tag,
    input  logic [15:0]             interval_ticks,
    output logic                    dispatch_valid,
    output logic [7:0]              dispatched_tag,
    output logic [3:0]              dispatched_slot,
    output logic [1:0]              status
);

    // Slot table; entries at or above the used count are never used.
    logic [15:0] reload_mem [tts_pkg::SLOTS];
    logic [15:0] cnt_mem    [tts_pkg::SLOTS];
    logic [7:0]  pend_mem   [tts_pkg::SLOTS];
    logic [7:0]  tag_mem    [tts_pkg::SLOTS];

    logic [tts_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic [tts_pkg::CNT_W-1:0]  used_reg, used_next;

    tts_pkg::cmd_e req_cmd_reg;
    logic [7:0]    req_tag_reg;
    logic [15:0]   req_ivl_reg;

    logic [15:0] cur_cnt_reg, cur_reload_reg;
    logic [7:0]  cur_pend_reg, cur_tag_reg;

    logic             res_valid_reg, res_valid_next;
    logic [7:0]       res_tag_reg, res_tag_next;
    logic [3:0]       res_slot_reg, res_slot_next;
    tts_pkg::status_e res_status_reg, res_status_next;

    logic [tts_pkg::SLOT_W-1:0] add_idx;
    logic [15:0] cnt_dec, cnt_val;
    logic [7:0]  pend_val;
    logic        in_range, last, found;
    logic        cnt_wr, pend_wr, add_wr;

    assign add_idx    = used_reg[tts_pkg::SLOT_W-1:0];
    assign cnt_dec    = cur_cnt_reg - 16'd1;
    assign in_range   = tts_pkg::CNT_W'(idx_reg) < used_reg;
    assign last       = (tts_pkg::CNT_W'(idx_reg) + tts_pkg::CNT_W'(1)) >= used_reg;
    assign found      = in_range && (cur_pend_reg != 8'd0);

    always_comb
    begin
        sts.done        = 1'b0;
        cnt_wr          = 1'b0;
        pend_wr         = 1'b0;
        add_wr          = 1'b0;
        cnt_val         = cnt_dec;
        pend_val        = cur_pend_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        res_valid_next  = res_valid_reg;
        res_tag_next    = res_tag_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;

        case (req_cmd_reg)
            tts_pkg::CMD_TICK:     sts.done = last;
            tts_pkg::CMD_DISPATCH: sts.done = last || found;
            default:               sts.done = 1'b1;
        endcase

        if (cmd.start)
        begin
            idx_next        = '0;
            res_valid_next  = 1'b0;
            res_tag_next    = 8'd0;
            res_slot_next   = 4'd0;
            res_status_next = (tts_pkg::cmd_e'(command) == tts_pkg::CMD_DISPATCH) ?
                              tts_pkg::ST_NONE : tts_pkg::ST_OK;
        end
        else if (cmd.step)
        begin
            if (!sts.done)
            begin
                idx_next = idx_reg + tts_pkg::SLOT_W'(1);
            end
            case (req_cmd_reg)
                tts_pkg::CMD_TICK:
                begin
                    if (in_range && (cur_cnt_reg != 16'd0))
                    begin
                        cnt_wr = 1'b1;
                        if (cnt_dec == 16'd0)
                        begin
                            // The slot fires: count it unless its pending count is saturated, and reload the countdown.
                            cnt_val = cur_reload_reg;
                            if (cur_pend_reg == 8'hFF)
                            begin
                                res_status_next = tts_pkg::ST_SAT;
                            end
                            else
                            begin
                                pend_wr  = 1'b1;
                                pend_val = cur_pend_reg + 8'd1;
                            end
                        end
                    end
                end
                tts_pkg::CMD_DISPATCH:
                begin
                    if (found)
                    begin
                        pend_wr         = 1'b1;
                        pend_val        = cur_pend_reg - 8'd1;
                        res_valid_next  = 1'b1;
                        res_tag_next    = cur_tag_reg;
                        res_slot_next   = 4'(idx_reg);
                        res_status_next = tts_pkg::ST_OK;
                    end
                end
                default:
                begin
                    if (used_reg == tts_pkg::CNT_W'(tts_pkg::SLOTS))
                    begin
                        res_status_next = tts_pkg::ST_FULL;
                    end
                    else
                    begin
                        add_wr    = 1'b1;
                        used_next = used_reg + tts_pkg::CNT_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_cmd_reg <= tts_pkg::cmd_e'(command);
            req_tag_reg <= task_tag;
            req_ivl_reg <= interval_ticks;
        end
        res_valid_reg  <= res_valid_next;
        res_tag_reg    <= res_tag_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        // The table is read one slot ahead, so the slot under idx_reg sits in the read registers;
        // a slot is written while it is the current one, except that an add writes the slot at the used count.
        cur_cnt_reg    <= cnt_mem[idx_next];
        cur_reload_reg <= reload_mem[idx_next];
        cur_pend_reg   <= pend_mem[idx_next];
        cur_tag_reg    <= tag_mem[idx_next];
        if (add_wr)
        begin
            reload_mem[add_idx] <= (req_cmd_reg == tts_pkg::CMD_ADD_PERIODIC) ?
                                   req_ivl_reg : 16'd0;
            cnt_mem[add_idx]    <= req_ivl_reg;
            pend_mem[add_idx]   <= 8'd0;
            tag_mem[add_idx]    <= req_tag_reg;
        end
        else
        begin
            if (cnt_wr)
            begin
                cnt_mem[idx_reg] <= cnt_val;
            end
            if (pend_wr)
            begin
                pend_mem[idx_reg] <= pend_val;
            end
        end
    end

    assign dispatch_valid  = res_valid_reg;
    assign dispatched_tag  = res_tag_reg;
    assign dispatched_slot = res_slot_reg;
    assign status          = res_status_reg;

    `TTS_ASSERT(a_used_bound, clk, rst_n, used_reg <= tts_pkg::CNT_W'(tts_pkg::SLOTS),
                "slot count beyond table size")
    `TTS_ASSERT(a_dispatch_ok, clk, rst_n, res_valid_reg |-> (res_status_reg == tts_pkg::ST_OK),
                "dispatched task with bad status")
    `TTS_NEVER(a_add_when_full, clk, rst_n,
               add_wr && (used_reg == tts_pkg::CNT_W'(tts_pkg::SLOTS)), "add into a full table")

endmodule

### hw/rtl/tick_task_scheduler.sv
// Top level of the tick task scheduler.
//
//  channel  modport  payload
//  req      sink     command, task_tag, interval_ticks
//  rsp      source   dispatch_valid, dispatched_tag, dispatched_slot, status
//
// A request is accepted in the idle state, then walks the slot table one slot per cycle,
// and its result is ready on the cycle after the walk ends.
// An add writes the slot at the used count; a tick walks every used slot; a dispatch stops at the first pending slot.
// Reset clears the used-slot count and slot index but not the slot table; no clearing pass is needed.
// A result waits in its output register until taken; no request is accepted meanwhile.
module tick_task_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    tts_req_if.sink    req,
    tts_rsp_if.source  rsp
);

    tts_pkg::dp_cmd_t cmd;
    tts_pkg::dp_sts_t sts;

    tts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    tts_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .command         (req.command),
        .task_tag        (req.task_tag),
        .interval_ticks  (req.interval_ticks),
        .dispatch_valid  (rsp.dispatch_valid),
        .dispatched_tag  (rsp.dispatched_tag),
        .dispatched_slot (rsp.dispatched_slot),
        .status          (rsp.status)
    );

endmodule
